// ===== hw/rtl/dlvt_pkg.sv =====
// Shared types, constants and the sine table of the display-list vertex transform.
package dlvt_pkg;

  // Vertex table depth and address width
  localparam int MAX_POINTS = 256;
  localparam int VAW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Port widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Input tdata field positions
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_VX_LSB    = 8;
  localparam int IN_VY_LSB    = 24;
  localparam int IN_PAIR_LSB  = 40;
  localparam int IN_COLOR_LSB = 56;

  // Output tdata field positions
  localparam int OUT_X_LSB     = 0;
  localparam int OUT_Y_LSB     = 17;
  localparam int OUT_COLOR_LSB = 34;

  // Width of the world-space accumulator ahead of the final shift
  localparam int WW = 54;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_SCALE       = 3'd1,
    CFG_ANGLE       = 3'd2,
    CFG_LOC_X       = 3'd3,
    CFG_LOC_Y       = 3'd4,
    CFG_HALF_W      = 3'd5,
    CFG_HALF_H      = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_DRAW = 2'd1,
    OP_END  = 2'd2
  } op_t;

  // One queued command: a vertex store, a line to draw, or a lone end marker
  typedef struct packed {
    op_t         op;
    logic [7:0]  idx_a;
    logic [7:0]  idx_b;
    logic [31:0] data;
    logic        eol;
  } qent_t;

  // Transform settings seen by the back end
  typedef struct packed {
    logic [15:0]        scale;
    logic [8:0]         angle_deg;
    logic signed [15:0] loc_x;
    logic signed [15:0] loc_y;
    logic [14:0]        half_width;
    logic [14:0]        half_height;
  } xf_cfg_t;

  // Quarter-wave sine, Q1.15, 0 to 90 degrees
  localparam logic [15:0] QSIN [91] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  // Sine of a whole angle 0..359, Q1.15 in 17 signed bits
  function automatic logic signed [16:0] sine_deg(input logic [8:0] a);
    logic [8:0]         t;
    logic               neg;
    logic signed [16:0] mag;
    t   = a;
    neg = 1'b0;
    if (a <= 9'd90) begin
      t = a;
    end else if (a <= 9'd180) begin
      t = 9'd180 - a;
    end else if (a <= 9'd270) begin
      t   = a - 9'd180;
      neg = 1'b1;
    end else begin
      t   = 9'd360 - a;
      neg = 1'b1;
    end
    mag = $signed({1'b0, QSIN[t[6:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

// ===== hw/rtl/display_list_vertex_transform.sv =====
// Top level of the display-list vertex transform: settings, front end, queue, back end.
// Usage
//   Settings go in through the cfg_ channel (cfg_index selects the register,
//   cfg_data carries the value, cfg_ready is always high). Write them only
//   while the block is idle; indexes past the last register are ignored.
//   Input transactions on in_ carry either a vertex load (in_tuser low) or a
//   line command (in_tuser high, in_tlast marks the final line of the list).
//   Loads produce nothing. A drawn line produces a move to its start vertex
//   and then a colored line to its end vertex; a skipped line produces nothing
//   unless it is the final one, which then gives a single end marker.
// Issue and pipeline
//   A line issues one table read per end vertex, a load or an end marker a single
//   issue; a new line can issue while earlier ones are still in the pipeline. The move
//   reaches out_ through the queue, the table read, five transform stages and the
//   output register; the line follows it.
// Reset and stalls
//   rst_n (synchronous) empties the queue and pipeline and restores the
//   default settings; vertex table contents are undefined until loaded.
//   While a result waits on out_tready the transform pipeline holds, loads at
//   the queue head still drain, and in_tready drops once the 4-entry queue fills.
module display_list_vertex_transform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dlvt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlvt_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input items
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] vertex_index, [23:8] vertex_x, [39:24] vertex_y,
  // [55:40] line_pair, [87:56] line_color
  input  logic [dlvt_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tuser,   // [0] cmd
  input  logic                                  in_tlast,   // end_of_list
  // results
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [16:0] screen_x, [33:17] screen_y, [65:34] color, [71:66] zero
  output logic [dlvt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [dlvt_pkg::OUT_TUSER_W-1:0]      out_tuser,  // [1:0] kind, [2] list_end
  output logic                                  out_tlast   // last
);
  import dlvt_pkg::*;

  logic [7:0] point_count_r;
  xf_cfg_t    xf_cfg_r;
  logic       cfg_we;

  logic  q_push;
  qent_t q_entry;
  logic  q_full;
  logic  q_pop;
  qent_t q_head;
  logic  q_empty;

  // Settings registers; the write channel never stalls
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r        <= 8'd0;
      xf_cfg_r.scale       <= 16'd19200;
      xf_cfg_r.angle_deg   <= 9'd0;
      xf_cfg_r.loc_x       <= 16'sd0;
      xf_cfg_r.loc_y       <= 16'sd0;
      xf_cfg_r.half_width  <= 15'd0;
      xf_cfg_r.half_height <= 15'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count_r        <= cfg_data[7:0];
        CFG_SCALE:       xf_cfg_r.scale       <= cfg_data;
        CFG_ANGLE:       xf_cfg_r.angle_deg   <= cfg_data[8:0];
        CFG_LOC_X:       xf_cfg_r.loc_x       <= $signed(cfg_data);
        CFG_LOC_Y:       xf_cfg_r.loc_y       <= $signed(cfg_data);
        CFG_HALF_W:      xf_cfg_r.half_width  <= cfg_data[14:0];
        CFG_HALF_H:      xf_cfg_r.half_height <= cfg_data[14:0];
        default:         point_count_r        <= point_count_r;
      endcase
    end
  end

  // Classify each accepted transaction into a queue command
  dlvt_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .point_count (point_count_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // Decouple acceptance from the transform pipeline
  dlvt_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Store vertices, transform line ends and hold results for the receiver
  dlvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (xf_cfg_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/dlvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dlvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dlvt_fifo.sv =====
// Short command queue between the front and back ends.
module dlvt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dlvt_pkg::qent_t  push_data,
  output logic             full,
  input  logic             pop,
  output dlvt_pkg::qent_t  head,
  output logic             empty
);
  import dlvt_pkg::*;

  qent_t          mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);

endmodule

// ===== hw/rtl/dlvt_front.sv =====
// Front end: accept input transactions and classify them into queue commands.
module dlvt_front (
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dlvt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 in_tlast,
  input  logic [7:0]                           point_count,
  input  logic                                 q_full,
  output logic                                 q_push,
  output dlvt_pkg::qent_t                      q_entry
);
  import dlvt_pkg::*;

  logic        accept;
  logic [7:0]  slot;
  logic [15:0] vx;
  logic [15:0] vy;
  logic [7:0]  n1;
  logic [7:0]  n2;
  logic [31:0] color;
  logic        slot_ok;
  logic        skip;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign slot  = in_tdata[IN_SLOT_LSB +: 8];
  assign vx    = in_tdata[IN_VX_LSB +: 16];
  assign vy    = in_tdata[IN_VY_LSB +: 16];
  assign n1    = in_tdata[IN_PAIR_LSB + 8 +: 8];
  assign n2    = in_tdata[IN_PAIR_LSB +: 8];
  assign color = in_tdata[IN_COLOR_LSB +: 32];

  assign slot_ok = (int'(slot) < MAX_POINTS);

  // Drop lines that are degenerate or reach past the point count
  assign skip = (point_count == 8'd0) || (n1 == n2) ||
                (n1 >= point_count) || (n2 >= point_count) ||
                (int'(n1) >= MAX_POINTS) || (int'(n2) >= MAX_POINTS);

  always_comb begin
    q_entry = '0;
    q_push  = 1'b0;
    if (in_tuser == CMD_LOAD) begin
      q_entry.op    = OP_LOAD;
      q_entry.idx_a = slot;
      q_entry.data  = {vy, vx};
      q_push        = accept && slot_ok;
    end else if (!skip) begin
      q_entry.op    = OP_DRAW;
      q_entry.idx_a = n1;
      q_entry.idx_b = n2;
      q_entry.data  = color;
      q_entry.eol   = in_tlast;
      q_push        = accept;
    end else begin
      q_entry.op  = OP_END;
      q_entry.eol = 1'b1;
      q_push      = accept && in_tlast;
    end
  end

endmodule

// ===== hw/rtl/dlvt_back.sv =====
// Back end: vertex table, transform pipeline and output register.
module dlvt_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dlvt_pkg::xf_cfg_t                     cfg,
  input  logic                                  q_empty,
  input  dlvt_pkg::qent_t                       q_head,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dlvt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [dlvt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                  out_tlast
);
  import dlvt_pkg::*;

  typedef enum logic {
    IS_FIRST  = 1'b0,
    IS_SECOND = 1'b1
  } iss_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] color;
    logic        list_end;
    logic        last;
  } tag_t;

  iss_t state_r, state_nxt;

  logic       advance;
  logic       issue_load;
  logic       issue_pipe;
  logic       ram_re;
  logic [VAW-1:0] ram_raddr;
  logic [31:0]    ram_rdata;
  tag_t           tag_in;

  logic [6:1] vld_r;
  tag_t       tag_r [1:6];

  logic signed [16:0] sin_r, cos_r;
  logic signed [16:0] ox_r, oy_r;
  logic [8:0]         ang_red;
  logic [8:0]         ang_cos;

  logic signed [32:0] vx_e, vy_e, sc_e;
  logic signed [32:0] px_r, py_r;
  logic signed [34:0] dx_r, dy_r;
  logic signed [51:0] dx_e, dy_e, sin_e, cos_e;
  logic signed [51:0] mxc_r, mys_r, mxs_r, myc_r;
  logic signed [52:0] rx_r, ry_r;
  logic signed [WW-1:0] wx_r, wy_r;

  logic               out_valid_r;
  tag_t               out_tag_r;
  logic signed [16:0] out_x_r, out_y_r;

  // Divide by 2^33 toward zero, then clamp to the screen range
  function automatic logic signed [16:0] to_screen(input logic signed [WW-1:0] w);
    logic signed [WW-34:0] q;
    logic                  frac_nz;
    frac_nz = |w[32:0];
    q = w[WW-1:33];
    if (w[WW-1] && frac_nz) begin
      q = q + 1'b1;
    end
    if (q > (WW-33)'(65535)) begin
      return 17'sd65535;
    end else if (q < -(WW-33)'(65536)) begin
      return -17'sd65536;
    end
    return q[16:0];
  endfunction

  assign advance    = !out_valid_r || out_tready;
  assign issue_load = !q_empty && (q_head.op == OP_LOAD);
  assign issue_pipe = !q_empty && advance && (q_head.op != OP_LOAD);
  assign ram_re     = issue_pipe && (q_head.op == OP_DRAW);
  assign ram_raddr  = (state_r == IS_FIRST) ? VAW'(q_head.idx_a) : VAW'(q_head.idx_b);

  dlvt_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (issue_load),
    .waddr (VAW'(q_head.idx_a)),
    .wdata (q_head.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Issue sequencer: a line reads the table once per end vertex, everything else issues once
  always_comb begin
    state_nxt = state_r;
    q_pop     = issue_load;
    tag_in    = '0;
    unique case (q_head.op)
      OP_DRAW: begin
        if (state_r == IS_FIRST) begin
          tag_in.kind = KIND_MOVE;
          if (issue_pipe) begin
            state_nxt = IS_SECOND;
          end
        end else begin
          tag_in.kind     = KIND_LINE;
          tag_in.color    = q_head.data;
          tag_in.list_end = q_head.eol;
          tag_in.last     = 1'b1;
          if (issue_pipe) begin
            state_nxt = IS_FIRST;
            q_pop     = 1'b1;
          end
        end
      end
      OP_END: begin
        tag_in.kind     = KIND_END;
        tag_in.list_end = 1'b1;
        tag_in.last     = 1'b1;
        q_pop           = issue_pipe;
      end
      default: begin
        tag_in = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IS_FIRST;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Rotation and origin terms follow the settings
  always_comb begin
    ang_red = (cfg.angle_deg >= 9'd360) ? cfg.angle_deg - 9'd360 : cfg.angle_deg;
    ang_cos = (ang_red >= 9'd270) ? ang_red - 9'd270 : ang_red + 9'd90;
  end

  always_ff @(posedge clk) begin
    sin_r <= sine_deg(ang_red);
    cos_r <= sine_deg(ang_cos);
    ox_r  <= $signed({cfg.loc_x[15], cfg.loc_x}) + $signed({2'b00, cfg.half_width});
    oy_r  <= $signed({2'b00, cfg.half_height}) - $signed({cfg.loc_y[15], cfg.loc_y});
  end

  // Valid bits and tags advance together with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[5:1], issue_pipe};
      out_valid_r <= vld_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r[1] <= tag_in;
      for (int i = 2; i <= 6; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      out_tag_r <= tag_r[6];
    end
  end

  always_comb begin
    vx_e  = $signed({{17{ram_rdata[15]}}, ram_rdata[15:0]});
    vy_e  = $signed({{17{ram_rdata[31]}}, ram_rdata[31:16]});
    sc_e  = $signed({17'b0, cfg.scale});
    dx_e  = $signed({{17{dx_r[34]}}, dx_r});
    dy_e  = $signed({{17{dy_r[34]}}, dy_r});
    sin_e = $signed({{35{sin_r[16]}}, sin_r});
    cos_e = $signed({{35{cos_r[16]}}, cos_r});
  end

  // Datapath: scale, recenter, rotate, combine, offset, then to screen
  always_ff @(posedge clk) begin
    if (advance) begin
      px_r  <= vx_e * sc_e;
      py_r  <= vy_e * sc_e;
      dx_r  <= $signed({{2{px_r[32]}}, px_r}) - $signed({cfg.loc_x[15], cfg.loc_x, 18'b0});
      dy_r  <= $signed({{2{py_r[32]}}, py_r}) - $signed({cfg.loc_y[15], cfg.loc_y, 18'b0});
      mxc_r <= dx_e * cos_e;
      mys_r <= dy_e * sin_e;
      mxs_r <= dx_e * sin_e;
      myc_r <= dy_e * cos_e;
      rx_r  <= $signed({mxc_r[51], mxc_r}) - $signed({mys_r[51], mys_r});
      ry_r  <= $signed({mxs_r[51], mxs_r}) + $signed({myc_r[51], myc_r});
      wx_r  <= $signed({rx_r[52], rx_r}) + $signed({{4{ox_r[16]}}, ox_r, 33'b0});
      wy_r  <= $signed({{4{oy_r[16]}}, oy_r, 33'b0}) - $signed({ry_r[52], ry_r});
      if (tag_r[6].kind == KIND_END) begin
        out_x_r <= '0;
        out_y_r <= '0;
      end else begin
        out_x_r <= to_screen(wx_r);
        out_y_r <= to_screen(wy_r);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_tag_r.color, out_y_r, out_x_r};
  assign out_tuser  = {out_tag_r.list_end, out_tag_r.kind};
  assign out_tlast  = out_tag_r.last;

endmodule

// ===== hw/rtl/dlvt_checker.sv =====
// Port-level assertions for the display-list vertex transform, bound to the top level.
module dlvt_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [dlvt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input logic [dlvt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input logic                                  out_tlast
);
  import dlvt_pkg::*;

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A move never closes an item and carries no color
  a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_MOVE) |->
      !out_tlast && !out_tuser[2] && (out_tdata[OUT_COLOR_LSB +: 32] == 32'd0))
    else $error("malformed move result");

  // A line always closes its item
  a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_LINE) |-> out_tlast)
    else $error("line result without last");

  // An end marker is all zero and closes the list
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_END) |->
      out_tlast && out_tuser[2] && (out_tdata == '0))
    else $error("malformed end marker");

endmodule

bind display_list_vertex_transform dlvt_checker u_dlvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the display-list vertex transform.
`timescale 1ns / 1ps

module testbench;
  import dlvt_pkg::*;

  localparam int     CLK_HALF       = 5;
  localparam int     RESET_CYCLES   = 3;
  localparam int     SETTLE_CYCLES  = 24;    // loads give no result, so trailing loads get time to finish
  localparam int     QUIET_LIMIT    = 2000;  // cycles with no transaction on any port
  localparam int     REPORT_LIMIT   = 10;
  localparam int     RANDOM_PHASES  = 12;
  localparam int     ITEMS_PER_PHASE = 32;
  localparam longint ONE18          = longint'(1) << 18;
  localparam longint ONE33          = longint'(1) << 33;
  localparam longint SCREEN_MAX     = 65535;
  localparam longint SCREEN_MIN     = -65536;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  // One input transaction before packing onto the bus
  typedef struct {
    cmd_t        cmd;
    logic [7:0]  slot;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] pair;
    logic [31:0] color;
    logic        eol;
  } display_item_t;

  // One result transaction, fields as the block reports them
  typedef struct {
    kind_t       kind;
    logic [16:0] x;
    logic [16:0] y;
    logic [31:0] color;
    logic        list_end;
    logic        last;
  } screen_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   in_tlast  = 1'b0;

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // Predictor state: a shadow of the settings and the vertex table
  logic [7:0]         num_points  = 8'd0;
  logic [15:0]        scale_q6    = 16'd19200;
  logic [8:0]         angle       = 9'd0;
  logic signed [15:0] center_x    = 16'sd0;
  logic signed [15:0] center_y    = 16'sd0;
  logic [14:0]        half_w      = 15'd0;
  logic [14:0]        half_h      = 15'd0;
  logic [31:0]        vertex_mem [MAX_POINTS];

  // Stimulus side: slots already written by queued loads, so no line reads a blank slot
  bit                 slot_loaded [MAX_POINTS];
  display_item_t      items_to_send [$];
  screen_result_t     expected_screen [$];

  int n_queued      = 0;
  int n_issued      = 0;
  int n_in_accepted = 0;
  int n_out_seen    = 0;
  int n_failures    = 0;
  int quiet_cycles  = 0;
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;

  display_list_vertex_transform u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q1.15 sine of a whole angle 0..359 from the quarter-wave table
  function automatic longint sine_q15(input int deg);
    if (deg <= 90)  return longint'(QSIN[deg]);
    if (deg <= 180) return longint'(QSIN[180 - deg]);
    if (deg <= 270) return -longint'(QSIN[deg - 180]);
    return -longint'(QSIN[360 - deg]);
  endfunction

  function automatic longint screen_clip(input longint v);
    if (v > SCREEN_MAX) return SCREEN_MAX;
    if (v < SCREEN_MIN) return SCREEN_MIN;
    return v;
  endfunction

  // Scale, rotate about the center and map one stored vertex to screen space.
  // Everything stays exact in 64 bits; the final divide truncates toward zero.
  function automatic void project_vertex(input logic [7:0] slot,
                                         output logic [16:0] sx, output logic [16:0] sy);
    longint ang, s, c, vx, vy, dx, dy, rx, ry, wx, wy;
    ang = (angle >= 9'd360) ? angle - 9'd360 : angle;
    s   = sine_q15(int'(ang));
    c   = sine_q15(int'((ang >= 270) ? ang - 270 : ang + 90));
    vx  = longint'($signed(vertex_mem[slot][15:0]));
    vy  = longint'($signed(vertex_mem[slot][31:16]));
    dx  = vx * longint'(scale_q6) - longint'(center_x) * ONE18;
    dy  = vy * longint'(scale_q6) - longint'(center_y) * ONE18;
    rx  = dx * c - dy * s;
    ry  = dx * s + dy * c;
    wx  = rx + (longint'(center_x) + longint'(half_w)) * ONE33;
    wy  = (longint'(half_h) - longint'(center_y)) * ONE33 - ry;
    sx  = 17'(screen_clip(wx / ONE33));
    sy  = 17'(screen_clip(wy / ONE33));
  endfunction

  // Update the shadow table or queue the results one accepted item causes
  function automatic void transform_item(input display_item_t it);
    logic [7:0]     n1, n2;
    screen_result_t r;
    if (it.cmd == CMD_LOAD) begin
      vertex_mem[it.slot] = {it.vy, it.vx};
      return;
    end
    n1 = it.pair[15:8];
    n2 = it.pair[7:0];
    // Skipped line: drawing disabled, degenerate pair, or an index past the count
    if (num_points == 8'd0 || n1 == n2 || n1 >= num_points || n2 >= num_points) begin
      if (it.eol) begin
        r = '{KIND_END, 17'd0, 17'd0, 32'd0, 1'b1, 1'b1};
        expected_screen.push_back(r);
      end
      return;
    end
    r.kind     = KIND_MOVE;
    r.color    = 32'd0;
    r.list_end = 1'b0;
    r.last     = 1'b0;
    project_vertex(n1, r.x, r.y);
    expected_screen.push_back(r);
    r.kind     = KIND_LINE;
    r.color    = it.color;
    r.list_end = it.eol;
    r.last     = 1'b1;
    project_vertex(n2, r.x, r.y);
    expected_screen.push_back(r);
  endfunction

  task automatic note_failure(input string msg);
    if (n_failures < REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    n_failures++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_center();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  // Line-only fields of a load carry random noise that the block must ignore
  task automatic queue_load(input logic [7:0] slot, input logic [15:0] vx, input logic [15:0] vy);
    display_item_t it;
    it.cmd   = CMD_LOAD;
    it.slot  = slot;
    it.vx    = vx;
    it.vy    = vy;
    it.pair  = 16'($urandom);
    it.color = $urandom;
    it.eol   = 1'($urandom_range(0, 1));
    slot_loaded[slot] = 1'b1;
    items_to_send.push_back(it);
    n_queued++;
  endtask

  task automatic queue_line(input logic [15:0] pair, input logic [31:0] color, input logic eol);
    display_item_t it;
    it.cmd   = CMD_DRAW;
    it.slot  = 8'($urandom);
    it.vx    = 16'($urandom);
    it.vy    = 16'($urandom);
    it.pair  = pair;
    it.color = color;
    it.eol   = eol;
    items_to_send.push_back(it);
    n_queued++;
  endtask

  task automatic ensure_loaded(input logic [7:0] slot);
    if (!slot_loaded[slot]) queue_load(slot, rand_coord(), rand_coord());
  endtask

  // Mostly drawable lines with random content, plus loads, degenerate and
  // out-of-range pairs. Slots below the count get loaded before first use.
  task automatic queue_random_items(input int count);
    logic [7:0]  a, b, t;
    logic [7:0]  pc;
    int unsigned roll;
    logic        eol;
    pc = num_points;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      eol  = ($urandom_range(0, 6) == 0);
      if (roll < 25) begin
        queue_load(8'($urandom), rand_coord(), rand_coord());
      end else if (roll < 80 && pc >= 2) begin
        a = 8'($urandom_range(0, pc - 1));
        b = 8'($urandom_range(0, pc - 2));
        if (b >= a) b++;
        ensure_loaded(a);
        ensure_loaded(b);
        queue_line({a, b}, $urandom, eol);
      end else if (roll < 88 && pc >= 1) begin
        a = 8'($urandom_range(0, pc - 1));
        ensure_loaded(a);
        queue_line({a, a}, $urandom, eol);
      end else begin
        a = 8'($urandom_range(pc, 255));
        b = 8'($urandom);
        if (b < pc) ensure_loaded(b);
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
        queue_line({a, b}, $urandom, eol);
      end
    end
  endtask

  // Hold until every queued item is taken, every result is back, and the
  // pipeline has had time to finish trailing loads.
  task automatic wait_quiet();
    while (n_in_accepted != n_queued || expected_screen.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register; valid stays high so writes can go back to back
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POINT_COUNT: num_points = data[7:0];
      CFG_SCALE:       scale_q6   = data;
      CFG_ANGLE:       angle      = data[8:0];
      CFG_LOC_X:       center_x   = $signed(data);
      CFG_LOC_Y:       center_y   = $signed(data);
      CFG_HALF_W:      half_w     = data[14:0];
      CFG_HALF_H:      half_h     = data[14:0];
      default:         ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Program every register once the block is idle. Unused upper bits of the
  // narrow registers get random filler, which the block must drop.
  task automatic program_settings(input logic [7:0] pc, input logic [15:0] scl,
                                  input logic [8:0] ang, input logic [15:0] lx,
                                  input logic [15:0] ly, input logic [14:0] hw,
                                  input logic [14:0] hh);
    wait_quiet();
    cfg_write(CFG_POINT_COUNT, {8'($urandom), pc});
    cfg_write(CFG_SCALE,       scl);
    cfg_write(CFG_ANGLE,       {7'($urandom), ang});
    cfg_write(CFG_LOC_X,       lx);
    cfg_write(CFG_LOC_Y,       ly);
    cfg_write(CFG_HALF_W,      {1'($urandom), hw});
    cfg_write(CFG_HALF_H,      {1'($urandom), hh});
    cfg_release();
  endtask

  task automatic program_random();
    logic [7:0]  pc;
    logic [15:0] scl;
    logic [14:0] hw, hh;
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0)      pc = 8'd0;
    else if (roll == 1) pc = 8'd1;
    else if (roll < 4)  pc = 8'd255;
    else if (roll < 14) pc = 8'($urandom_range(2, 16));
    else                pc = 8'($urandom_range(17, 254));
    case ($urandom_range(0, 4))
      0:       scl = 16'd0;
      1:       scl = 16'hFFFF;
      2:       scl = 16'($urandom);
      default: scl = 16'($urandom_range(64, 25600));
    endcase
    hw = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1023));
    hh = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1023));
    program_settings(pc, scl, 9'($urandom_range(0, 511)), rand_center(), rand_center(), hw, hh);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: launch input transactions and toggle backpressure on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ports
    display_item_t nxt;
    // Hold a pending transaction until the block takes it
    if (rst_n && (!in_tvalid || n_in_accepted == n_issued)) begin
      if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt = items_to_send.pop_front();
        in_tdata  <= {nxt.color, nxt.pair, nxt.vy, nxt.vx, nxt.slot};
        in_tuser  <= nxt.cmd;
        in_tlast  <= nxt.eol;
        in_tvalid <= 1'b1;
        n_issued++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted inputs, check accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    display_item_t  seen;
    screen_result_t got, want;
    logic [5:0]     pad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.cmd   = cmd_t'(in_tuser);
        seen.slot  = in_tdata[IN_SLOT_LSB +: 8];
        seen.vx    = in_tdata[IN_VX_LSB +: 16];
        seen.vy    = in_tdata[IN_VY_LSB +: 16];
        seen.pair  = in_tdata[IN_PAIR_LSB +: 16];
        seen.color = in_tdata[IN_COLOR_LSB +: 32];
        seen.eol   = in_tlast;
        transform_item(seen);
        n_in_accepted <= n_in_accepted + 1;
      end
      if (out_tvalid && out_tready) begin
        got.kind     = kind_t'(out_tuser[1:0]);
        got.list_end = out_tuser[2];
        got.x        = out_tdata[OUT_X_LSB +: 17];
        got.y        = out_tdata[OUT_Y_LSB +: 17];
        got.color    = out_tdata[OUT_COLOR_LSB +: 32];
        got.last     = out_tlast;
        pad          = out_tdata[OUT_TDATA_W-1 -: 6];
        if (expected_screen.size() == 0) begin
          note_failure($sformatf("result %0d unexpected: kind %0d x %0d y %0d color %h",
                                 n_out_seen, got.kind, $signed(got.x), $signed(got.y),
                                 got.color));
        end else begin
          want = expected_screen.pop_front();
          if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
              got.color !== want.color || got.list_end !== want.list_end ||
              got.last !== want.last || pad !== 6'd0) begin
            note_failure($sformatf({"result %0d: expected kind %0d x %0d y %0d color %h ",
                                    "end %b last %b; got kind %0d x %0d y %0d color %h ",
                                    "end %b last %b pad %h"},
                                   n_out_seen, want.kind, $signed(want.x), $signed(want.y),
                                   want.color, want.list_end, want.last,
                                   got.kind, $signed(got.x), $signed(got.y),
                                   got.color, got.list_end, got.last, pad));
          end
        end
        n_out_seen++;
      end
    end
  end

  // Watchdog: a stuck handshake on every port ends the run
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int ph;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Slow sender side is rare, receiver stalls often
    send_gap_pct   = 7;
    recv_stall_pct = 79;

    // Reset settings have zero points: lines only ever give a lone end marker
    queue_load(8'd0, 16'h7FFF, 16'h8000);
    queue_load(8'd1, 16'h8000, 16'h7FFF);
    queue_load(8'd2, 16'h0000, 16'h0000);
    queue_load(8'd3, 16'hFFFF, 16'h0001);
    queue_line({8'd0, 8'd1}, 32'hDEAD_BEEF, 1'b1);
    queue_line({8'd2, 8'd3}, 32'h1234_5678, 1'b0);

    // Typical screen, small angle; degenerate and out-of-range pairs, the
    // final line drawn as well as skipped
    program_settings(8'd4, 16'd19200, 9'd30, 16'd100, -16'sd50, 15'd320, 15'd240);
    cfg_write(CFG_UNMAPPED, 16'hA5A5);
    cfg_release();
    queue_line({8'd0, 8'd1}, 32'hFFFF_FFFF, 1'b0);
    queue_line({8'd2, 8'd3}, 32'h0000_0000, 1'b1);
    queue_line({8'd1, 8'd1}, $urandom, 1'b1);
    queue_line({8'd0, 8'd4}, $urandom, 1'b0);
    queue_line({8'd4, 8'd0}, $urandom, 1'b1);
    queue_line({8'd3, 8'd2}, $urandom, 1'b0);

    // Half turn with extreme scale and center: drives x into negative saturation
    program_settings(8'd255, 16'hFFFF, 9'd180, 16'h8000, 16'h7FFF, 15'd0, 15'h7FFF);
    queue_line({8'd0, 8'd1}, $urandom, 1'b1);
    queue_line({8'd1, 8'd3}, $urandom, 1'b0);
    queue_line({8'd255, 8'd0}, $urandom, 1'b1);

    // Zero scale, opposite extremes: positive saturation on both axes
    program_settings(8'd4, 16'd0, 9'd180, 16'h7FFF, 16'h8000, 15'h7FFF, 15'd0);
    queue_line({8'd1, 8'd0}, $urandom, 1'b0);
    queue_line({8'd3, 8'd2}, $urandom, 1'b1);

    // Angle past a full turn wraps back by 360
    program_settings(8'd4, 16'hFFFF, 9'd511, 16'h8000, 16'h7FFF, 15'd0, 15'h7FFF);
    queue_line({8'd0, 8'd2}, $urandom, 1'b0);

    // Quarter turns and the exact full turn
    program_settings(8'd4, 16'd19200, 9'd90, 16'd0, 16'd0, 15'd400, 15'd400);
    queue_line({8'd0, 8'd1}, $urandom, 1'b0);
    queue_line({8'd2, 8'd3}, $urandom, 1'b0);
    program_settings(8'd4, 16'd19200, 9'd270, 16'd0, 16'd0, 15'd400, 15'd400);
    queue_line({8'd1, 8'd0}, $urandom, 1'b0);
    program_settings(8'd4, 16'd19200, 9'd360, 16'd0, 16'd0, 15'd400, 15'd400);
    queue_line({8'd0, 8'd3}, $urandom, 1'b1);

    // Random phases: swap the idling pattern a third of the way in, then drop it
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES / 3) begin
        send_gap_pct   = 79;
        recv_stall_pct = 7;
      end else if (ph == 2 * RANDOM_PHASES / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      program_random();
      queue_random_items(ITEMS_PER_PHASE);
    end

    wait_quiet();
    if (n_failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dlvt_pkg.sv
hw/rtl/dlvt_ram.sv
hw/rtl/dlvt_fifo.sv
hw/rtl/dlvt_front.sv
hw/rtl/dlvt_back.sv
hw/rtl/display_list_vertex_transform.sv
hw/rtl/dlvt_checker.sv
sim/testbench.sv
